// File: rtl/hpt_pkg.sv
// Package for the heartbeat presence table: sizes, codes and the
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

  // Table geometry
  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  // Field widths
  localparam int unsigned ID_W     = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd5000;
  localparam logic [ID_W-1:0]   MARKER_RST  = 16'hFFFF;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER  = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_HEARTBEAT = 2'd1,
    OP_CHECK     = 2'd2,
    OP_LOOKUP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED     = 4'd0,
    ST_KNOWN       = 4'd1,
    ST_ADDED       = 4'd2,
    ST_FULL        = 4'd3,
    ST_REFRESHED   = 4'd4,
    ST_BACK_ONLINE = 4'd5,
    ST_CHECKED     = 4'd6,
    ST_HIT         = 4'd7,
    ST_MISS        = 4'd8
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              load;    // capture an accepted item, clear the scan
    logic              scan;    // visit slot idx
    logic              commit;  // apply the update and load the result
    logic [SLOT_W-1:0] idx;
  } hpt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_blocked;  // result register full and stalled
  } hpt_sts_t;

endpackage

`default_nettype wire

// File: rtl/hpt_ctrl.sv
// Controller of the heartbeat presence table: accept, slot scan, commit.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpt_ctrl
  import hpt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire hpt_sts_t sts_i,
  output hpt_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              last_slot;

  assign last_slot = (idx_q == SLOT_W'(SLOTS - 1));

  // Sequence one item through the table
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    in_stall_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (last_slot) begin
          state_d = S_COMMIT;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      S_COMMIT: begin
        // hold while the previous result has not been taken
        if (!sts_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hpt_datapath.sv
// Datapath of the heartbeat presence table: slot storage, configuration
// registers, scan accumulators and the result register. Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpt_datapath
  import hpt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire hpt_cmd_t              cmd_i,
  output hpt_sts_t                   sts_o,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // item fields
  input  wire logic [1:0]            opcode_i,
  input  wire logic [ID_W-1:0]       node_id_i,
  input  wire logic [TIME_W-1:0]     now_ms_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic                       hit_o,
  output logic                       node_online_o,
  output logic [TIME_W-1:0]          node_last_seen_o,
  output logic [OCC_W-1:0]           occupied_o,
  output logic                       offline_present_o,
  output logic [ID_W-1:0]            offline_id_o
);

  // Configuration registers
  logic [TIME_W-1:0] timeout_q;
  logic [ID_W-1:0]   marker_q;

  // Slot storage
  logic [ID_W-1:0]   slot_id_q     [SLOTS];
  logic [SLOTS-1:0]  slot_online_q;
  logic [TIME_W-1:0] slot_seen_q   [SLOTS];

  // Captured item
  op_e               op_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] now_q;

  // Scan accumulators
  logic              match_found_q, free_found_q, off1_found_q, off2_found_q;
  logic [SLOT_W-1:0] match_idx_q, free_idx_q, off1_idx_q;
  logic              match_online_q;
  logic [TIME_W-1:0] match_seen_q;
  logic [ID_W-1:0]   off1_id_q, off2_id_q;
  logic [CNT_W-1:0]  occ_q;

  // Result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic                hit_q, online_q, offp_q;
  logic [TIME_W-1:0]   seen_q;
  logic [OCC_W-1:0]    occ_out_q;
  logic [ID_W-1:0]     offid_q;

  // Scan of the current slot
  logic [ID_W-1:0]   scan_id;
  logic              scan_occ, scan_match, scan_on_old, scan_expire, scan_off;
  logic [TIME_W-1:0] scan_age;

  // Commit decisions
  logic          id_is_marker;
  logic          wr_en, wr_new, occ_inc, res_hit, use_second;
  logic [SLOT_W-1:0] wr_idx;
  status_e       res_status;

  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      marker_q  <= MARKER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_MARKER:  marker_q  <= cfg_data_i[ID_W-1:0];
        default:     timeout_q <= timeout_q;
      endcase
    end
  end

  // Evaluate the slot under the scan pointer
  always_comb begin
    scan_id     = slot_id_q[cmd_i.idx];
    scan_occ    = (scan_id != marker_q);
    scan_match  = scan_occ && (scan_id == id_q);
    scan_on_old = slot_online_q[cmd_i.idx];
    scan_age    = now_q - slot_seen_q[cmd_i.idx];
    scan_expire = (op_q == OP_CHECK) && scan_occ && scan_on_old && (scan_age > timeout_q);
    scan_off    = scan_occ && !(scan_on_old && !scan_expire);
  end

  // Capture the item, then gather per-slot facts during the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      off1_found_q  <= 1'b0;
      off2_found_q  <= 1'b0;
    end else if (cmd_i.load) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      off1_found_q  <= 1'b0;
      off2_found_q  <= 1'b0;
    end else if (cmd_i.scan) begin
      if (scan_match) match_found_q <= 1'b1;
      if (!scan_occ)  free_found_q  <= 1'b1;
      if (scan_off) begin
        if (!off1_found_q) off1_found_q <= 1'b1;
        else               off2_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_e'(opcode_i);
      id_q      <= node_id_i;
      now_q     <= now_ms_i;
      occ_q     <= '0;
      off1_id_q <= '0;
      off2_id_q <= '0;
    end else if (cmd_i.scan) begin
      if (scan_match && !match_found_q) begin
        match_idx_q    <= cmd_i.idx;
        match_online_q <= scan_on_old;
        match_seen_q   <= slot_seen_q[cmd_i.idx];
      end
      if (!scan_occ && !free_found_q) begin
        free_idx_q <= cmd_i.idx;
      end
      if (scan_occ) begin
        occ_q <= occ_q + CNT_W'(1);
      end
      if (scan_off) begin
        if (!off1_found_q) begin
          off1_idx_q <= cmd_i.idx;
          off1_id_q  <= scan_id;
        end else if (!off2_found_q) begin
          off2_id_q <= scan_id;
        end
      end
    end
  end

  // Decide the update and the status of the item
  always_comb begin
    id_is_marker = (id_q == marker_q);
    wr_en        = 1'b0;
    wr_new       = 1'b0;
    wr_idx       = match_idx_q;
    occ_inc      = 1'b0;
    res_hit      = 1'b0;
    res_status   = ST_CHECKED;
    case (op_q)
      OP_ADD, OP_HEARTBEAT: begin
        if (id_is_marker) begin
          res_status = ST_IGNORED;
        end else if (match_found_q) begin
          if (op_q == OP_ADD) begin
            res_status = ST_KNOWN;
          end else begin
            res_status = match_online_q ? ST_REFRESHED : ST_BACK_ONLINE;
            wr_en      = 1'b1;
          end
        end else if (free_found_q) begin
          res_status = ST_ADDED;
          wr_en      = 1'b1;
          wr_new     = 1'b1;
          wr_idx     = free_idx_q;
          occ_inc    = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_CHECK: begin
        res_status = ST_CHECKED;
      end
      OP_LOOKUP: begin
        res_hit    = match_found_q;
        res_status = match_found_q ? ST_HIT : ST_MISS;
      end
      default: begin
        res_status = ST_CHECKED;
      end
    endcase
    // a first-offline slot that comes back online hands the report to the next one
    use_second = wr_en && !wr_new && !match_online_q && off1_found_q
                 && (off1_idx_q == match_idx_q);
  end

  // Update the slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_id_q[i] <= MARKER_RST;
      end
      slot_online_q <= '0;
    end else begin
      if (cmd_i.scan && scan_expire) begin
        slot_online_q[cmd_i.idx] <= 1'b0;
      end
      if (cmd_i.commit && wr_en) begin
        slot_online_q[wr_idx] <= 1'b1;
        if (wr_new) begin
          slot_id_q[wr_idx] <= id_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      slot_seen_q[wr_idx] <= now_q;
    end
  end

  // Result register: load on commit, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= res_status;
      hit_q     <= res_hit;
      online_q  <= res_hit && match_online_q;
      seen_q    <= res_hit ? match_seen_q : '0;
      occ_out_q <= OCC_W'(occ_q + CNT_W'(occ_inc));
      offp_q    <= use_second ? off2_found_q : off1_found_q;
      offid_q   <= use_second ? off2_id_q : off1_id_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign hit_o             = hit_q;
  assign node_online_o     = online_q;
  assign node_last_seen_o  = seen_q;
  assign occupied_o        = occ_out_q;
  assign offline_present_o = offp_q;
  assign offline_id_o      = offid_q;

endmodule

`default_nettype wire

// File: rtl/heartbeat_presence_table_top.sv
// Top level of the heartbeat presence table: controller plus datapath.
// Depends on hpt_pkg, hpt_ctrl and hpt_datapath.
//
//   Port group   Direction  Handshake              Payload
//   in_*         in         in_valid_i/in_stall_o  opcode_i, node_id_i, now_ms_i
//   out_*        out        out_valid_o/out_stall_i status_o ... offline_id_o
//   cfg_*        in         cfg_valid_i/cfg_ready_o cfg_idx_i, cfg_data_i
//
// An item is accepted, then the scan walks the table slot by slot, then
// the update is committed; the commit holds while an earlier result waits.
// Items are handled one at a time.
// Reset sets every slot free and offline and loads the register defaults.
// A finished result waits in the output register; the next item is taken
// meanwhile, and its commit holds until the waiting result is transferred.
`timescale 1ns / 1ps
`default_nettype none

module heartbeat_presence_table_top
  import hpt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [ID_W-1:0]       node_id_i,
  input  wire logic [TIME_W-1:0]     now_ms_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic                       hit_o,
  output logic                       node_online_o,
  output logic [TIME_W-1:0]          node_last_seen_o,
  output logic [OCC_W-1:0]           occupied_o,
  output logic                       offline_present_o,
  output logic [ID_W-1:0]            offline_id_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  hpt_cmd_t cmd;
  hpt_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpt_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .node_id_i         (node_id_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .hit_o             (hit_o),
    .node_online_o     (node_online_o),
    .node_last_seen_o  (node_last_seen_o),
    .occupied_o        (occupied_o),
    .offline_present_o (offline_present_o),
    .offline_id_o      (offline_id_o)
  );

  // An accepted item blocks the input until its update is committed
  a_accept_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again straight after a transfer");

  // Hit flag agrees with the lookup status
  a_hit_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == (status_o == ST_HIT)))
    else $error("hit flag disagrees with status");

  // Occupancy never exceeds the table size
  a_occ_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occupied_o <= OCC_W'(SLOTS)))
    else $error("occupied count beyond table size");

  // No offline id without an offline slot
  a_offline_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !offline_present_o) |-> (offline_id_o == '0))
    else $error("offline id reported with none present");

endmodule

`default_nettype wire
